// ===== sv/sutl_pkg.sv =====
`timescale 1ns / 1ps

package sutl_pkg;

  // Default list depth
  localparam int unsigned CapacityDef = 64;

  // Request codes
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  // IDs up to this value are reserved and never stored
  localparam logic [7:0] RESERVED_MAX_ID = 8'd3;

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned EntryW = 7;

endpackage

// ===== sv/sorted_unique_id_target_list_top.sv =====
`timescale 1ns / 1ps

// Sorted unique tag list with a target cursor. Tag reports (req_type 0) with an
// ID above 3 are inserted in ascending order, duplicates are skipped, and a new
// ID arriving at a full list is dropped with dropped_full set; after any such
// report the target is the lowest stored ID. An advance request (req_type 1)
// steps the cursor to the next entry, makes it the target and pulses
// clear_target_coord; on the last entry or an empty list nothing changes. An
// obstacle query (req_type 2) flags an ID stored anywhere but the first slot.
// The cursor keeps its slot number across inserts. One request is worked at a
// time, and in_stall_o stays high until its response is registered. The IDs
// live in a memory with separate read and write ports (one write, one
// registered read per cycle) and a sequencer walks it one entry per cycle: an
// insert compares and ripple-shifts in the same pass, a query stops at the
// first match, an advance reads its entry at accept, and reserved or unknown
// requests go straight to ST_DONE. The response waits in an output
// register, so the next request can be taken while it is still stalled. The
// memory needs no clearing after reset: only slots below the count are used.

module sorted_unique_id_target_list_top #(
  parameter int unsigned CAPACITY = sutl_pkg::CapacityDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [sutl_pkg::IdW-1:0]     tag_id_i,
  // response channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sutl_pkg::IdW-1:0]     target_id_o,
  output logic                         clear_target_coord_o,
  output logic                         is_obstacle_o,
  output logic                         dropped_full_o,
  output logic [sutl_pkg::EntryW-1:0]  entry_count_o
);
  import sutl_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_ADV,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic                 query_q;     // scan serves a query, not an insert
  logic                 ins_q;       // new ID written, ripple shift running
  logic [IdW-1:0]       id_q;
  logic [IdW-1:0]       carry_q;     // entry displaced by the shift
  logic [IdW-1:0]       head_q;      // copy of slot 0
  logic [AddrW-1:0]     idx_q;       // slot whose data sits in rdata_q
  logic [CntW-1:0]      count_q;
  logic [AddrW-1:0]     cursor_q;
  logic [IdW-1:0]       target_q;
  logic                 clr_q;
  logic                 obs_q;
  logic                 drop_q;

  logic                 out_valid_q;
  logic [IdW-1:0]       out_target_q;
  logic                 out_clr_q;
  logic                 out_obs_q;
  logic                 out_drop_q;
  logic [CntW-1:0]      out_count_q;

  // ID memory
  logic [IdW-1:0]       mem_q [CAPACITY];
  logic [IdW-1:0]       rdata_q;
  logic [AddrW-1:0]     rd_addr;
  logic                 we;
  logic [AddrW-1:0]     wa;
  logic [IdW-1:0]       wd;

  logic                 accept;
  logic                 last;
  logic                 full;
  logic [AddrW-1:0]     cursor_nxt;
  logic                 can_adv;
  logic [CntW+EntryW-1:0] count_ext;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign full       = (count_q == CntW'(CAPACITY));
  assign last       = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign cursor_nxt = cursor_q + AddrW'(1);
  assign can_adv    = ((CntW'(cursor_q) + CntW'(1)) < count_q);

  // read address: first slot of the pass at accept, then the slot after idx
  always_comb begin
    rd_addr = idx_q + AddrW'(1);
    if (state_q == ST_IDLE) begin
      case (req_type_i)
        REQ_INSERT:  rd_addr = '0;
        REQ_ADVANCE: rd_addr = cursor_nxt;
        default:     rd_addr = AddrW'(1);
      endcase
    end
  end

  // write port: new ID at its slot, then the displaced entries one slot up
  always_comb begin
    we = 1'b0;
    wa = idx_q;
    wd = carry_q;
    if (state_q == ST_SCAN && !query_q) begin
      if (ins_q) begin
        we = 1'b1;
      end else if (rdata_q > id_q && !full) begin
        we = 1'b1;
        wd = id_q;
      end
    end else if (state_q == ST_TAIL && (ins_q || !full)) begin
      we = 1'b1;
      wa = count_q[AddrW-1:0];
      wd = ins_q ? carry_q : id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      query_q      <= 1'b0;
      ins_q        <= 1'b0;
      id_q         <= '0;
      carry_q      <= '0;
      head_q       <= '0;
      idx_q        <= '0;
      count_q      <= '0;
      cursor_q     <= '0;
      target_q     <= '0;
      clr_q        <= 1'b0;
      obs_q        <= 1'b0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_target_q <= '0;
      out_clr_q    <= 1'b0;
      out_obs_q    <= 1'b0;
      out_drop_q   <= 1'b0;
      out_count_q  <= '0;
    end else begin
      // response taken; a finished request reloads it in ST_DONE instead
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            id_q    <= tag_id_i;
            clr_q   <= 1'b0;
            obs_q   <= 1'b0;
            drop_q  <= 1'b0;
            ins_q   <= 1'b0;
            query_q <= (req_type_i == REQ_QUERY);
            case (req_type_i)
              REQ_INSERT: begin
                if (tag_id_i > RESERVED_MAX_ID) begin
                  idx_q   <= '0;
                  state_q <= (count_q == '0) ? ST_TAIL : ST_SCAN;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              REQ_ADVANCE: begin
                state_q <= can_adv ? ST_ADV : ST_DONE;
              end
              REQ_QUERY: begin
                if (count_q > CntW'(1)) begin
                  idx_q   <= AddrW'(1);
                  state_q <= ST_SCAN;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + AddrW'(1);
          if (query_q) begin
            if (rdata_q == id_q) begin
              obs_q   <= 1'b1;
              state_q <= ST_DONE;
            end else if (last) begin
              state_q <= ST_DONE;
            end
          end else if (ins_q) begin
            carry_q <= rdata_q;
            if (last) begin
              state_q <= ST_TAIL;
            end
          end else if (rdata_q == id_q) begin
            // duplicate
            target_q <= head_q;
            state_q  <= ST_DONE;
          end else if (rdata_q > id_q) begin
            if (full) begin
              drop_q   <= 1'b1;
              target_q <= head_q;
              state_q  <= ST_DONE;
            end else begin
              ins_q   <= 1'b1;
              carry_q <= rdata_q;
              if (idx_q == '0) begin
                head_q <= id_q;
              end
              if (last) begin
                state_q <= ST_TAIL;
              end
            end
          end else if (last) begin
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (!ins_q && full) begin
            drop_q   <= 1'b1;
            target_q <= head_q;
          end else begin
            count_q <= count_q + CntW'(1);
            if (count_q == '0) begin
              head_q   <= id_q;
              target_q <= id_q;
            end else begin
              target_q <= head_q;
            end
          end
          state_q <= ST_DONE;
        end
        ST_ADV: begin
          cursor_q <= cursor_nxt;
          target_q <= rdata_q;
          clr_q    <= 1'b1;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_target_q <= target_q;
            out_clr_q    <= clr_q;
            out_obs_q    <= obs_q;
            out_drop_q   <= drop_q;
            out_count_q  <= count_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // count reported modulo 128
  assign count_ext = {{EntryW{1'b0}}, out_count_q};

  assign out_valid_o          = out_valid_q;
  assign target_id_o          = out_target_q;
  assign clear_target_coord_o = out_clr_q;
  assign is_obstacle_o        = out_obs_q;
  assign dropped_full_o       = out_drop_q;
  assign entry_count_o        = count_ext[EntryW-1:0];

endmodule
